/* sv/smtq_pkg.sv */
// smtq_pkg: shared types and codes for the sorted timer queue
// no dependencies
package smtq_pkg;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_TAG   = 3'd3,
    OP_TIME  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FAIL  = 2'd1,
    KIND_EXP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FLAG_FREE  = 2'd0,
    FLAG_ALLOC = 2'd1,
    FLAG_RUN   = 2'd2
  } flag_t;

  // one result word between engine and output register
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_id;
    logic [31:0] tag_out;
    logic [2:0]  queue_id;
    logic        last;
  } result_t;

endpackage

/* sv/smtq_out_reg.sv */
// smtq_out_reg: single output register with valid/stall handshake
// depends on smtq_pkg
module smtq_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  smtq_pkg::result_t din,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output smtq_pkg::result_t dout
);
  import smtq_pkg::*;

  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

/* sv/smtq_engine.sv */
// smtq_engine: slot memories and the sequencer for alloc, insert and pop
// depends on smtq_pkg
module smtq_engine #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [3:0]        timer_id,
  input  logic [31:0]       delay_ticks,
  input  logic signed [31:0] tag_value,
  input  logic [2:0]        queue_select,
  output logic              res_load,
  output smtq_pkg::result_t res,
  input  logic              res_busy
);
  import smtq_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ADDR_SLOTS = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int FW = $clog2(ADDR_SLOTS + 1);
  localparam int RW = $bits(result_t);

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_INS_CMP, S_WALK_CMP, S_INS_LINK,
    S_POP_RD, S_POP_CMP, S_DONE
  } state_t;

  // slot memories: deadline and link in separate arrays, tag+queue together
  logic [31:0]    dl_mem   [NUM_SLOTS];
  logic [AW-1:0]  lk_mem   [NUM_SLOTS];
  logic [34:0]    tq_mem   [NUM_SLOTS];
  // flags are small and scanned whole, kept in flops
  logic [1:0]     flags    [NUM_SLOTS];

  logic [AW-1:0]  rd_addr;
  logic           rd_en;
  logic [31:0]    rd_dl;
  logic [AW-1:0]  rd_lk;
  logic [34:0]    rd_tq;

  logic           dl_we, lk_we, tq_we;
  logic [AW-1:0]  dl_wa, lk_wa, tq_wa;
  logic [31:0]    dl_wd;
  logic [AW-1:0]  lk_wd;
  logic [34:0]    tq_wd;

  state_t         state;
  logic [AW-1:0]  head;
  logic [31:0]    tick_count;
  logic [31:0]    earliest;
  logic [AW-1:0]  x_slot;
  logic [31:0]    x_dl;
  logic [AW-1:0]  cur;
  logic [AW-1:0]  nxt;
  logic [CW-1:0]  steps;
  logic [FW-1:0]  pops;
  logic [AW-1:0]  scan;
  logic           pend;
  logic           held;
  result_t        pend_res;

  logic           addr_ok;
  logic [31:0]    tick_next;
  logic           due;
  logic           can_load;
  logic           pend_go;
  logic           pop_go;
  logic           pop_end;

  assign addr_ok = (timer_id != 4'd0) && (32'(timer_id) < 32'(ADDR_SLOTS));
  assign tick_next = tick_count + 32'd1;
  assign in_stall = (state != S_IDLE) || pend;
  assign due = (cur != '0) && (pops != '0) && (rd_dl <= tick_count);
  assign can_load = !res_busy && !res_load;
  assign pend_go = pend && can_load;
  // a popped word is held until the next compare tells whether it is the last
  assign pop_go = (state == S_POP_CMP) && due && (!held || can_load);
  assign pop_end = (state == S_POP_CMP) && !due && (!held || can_load);

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    if (tq_we) tq_mem[tq_wa] <= tq_wd;
    if (rd_en) begin
      rd_dl <= (dl_we && dl_wa == rd_addr) ? dl_wd : dl_mem[rd_addr];
      rd_lk <= (lk_we && lk_wa == rd_addr) ? lk_wd : lk_mem[rd_addr];
      rd_tq <= tq_mem[rd_addr];
    end
  end

  // combinational control of memory ports
  always_comb begin
    rd_en = 1'b0;
    rd_addr = head;
    dl_we = 1'b0; dl_wa = AW'(timer_id); dl_wd = tick_count + delay_ticks;
    lk_we = 1'b0; lk_wa = x_slot; lk_wd = cur;
    tq_we = 1'b0; tq_wa = AW'(timer_id); tq_wd = {tag_value, queue_select};
    unique case (state)
      S_IDLE: begin
        if (in_valid && !pend) begin
          if (opcode == OP_TAG && addr_ok) tq_we = 1'b1;
          if (opcode == OP_TIME && addr_ok) begin
            dl_we = 1'b1;
            rd_en = 1'b1;
            rd_addr = head;
          end
          if (opcode == OP_TICK) begin
            rd_en = 1'b1;
            rd_addr = head;
          end
        end
      end
      S_INS_CMP: begin
        if (x_dl <= rd_dl) begin
          lk_we = 1'b1; lk_wa = x_slot; lk_wd = cur;
        end else begin
          rd_en = 1'b1; rd_addr = rd_lk;
        end
      end
      S_WALK_CMP: begin
        if (x_dl <= rd_dl) begin
          lk_we = 1'b1; lk_wa = cur; lk_wd = x_slot;
        end else if (steps != CW'(1)) begin
          rd_en = 1'b1; rd_addr = rd_lk;
        end
      end
      S_INS_LINK: begin
        lk_we = 1'b1; lk_wa = x_slot; lk_wd = nxt;
      end
      S_POP_CMP: begin
        if (pop_go) begin
          rd_en = 1'b1; rd_addr = rd_lk;
        end
      end
      default: ;
    endcase
    // sentinel deadline is written while reset is held
    if (rst) begin
      rd_en = 1'b0;
      lk_we = 1'b0;
      tq_we = 1'b0;
      dl_we = 1'b1; dl_wa = '0; dl_wd = ALL_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      tick_count <= '0;
      earliest <= ALL_ONES;
      pend <= 1'b0;
      held <= 1'b0;
      res_load <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) flags[i] <= (i == 0) ? FLAG_RUN : FLAG_FREE;
    end else begin
      res_load <= pend_go || ((pop_go || pop_end) && held);
      // deliver a result word when the output register frees up
      if (pend_go) begin
        res <= pend_res;
        pend <= 1'b0;
      end else if (pop_go) begin
        res <= pend_res;
      end else if (pop_end) begin
        res <= result_t'({pend_res[RW-1:1], 1'b1});
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !pend) begin
            unique case (opcode)
              OP_TICK: begin
                tick_count <= tick_next;
                if (earliest <= tick_next) begin
                  cur <= head;
                  pops <= FW'(ADDR_SLOTS);
                  state <= S_POP_CMP;
                end
              end
              OP_ALLOC: begin
                scan <= '0;
                state <= S_ALLOC;
              end
              OP_FREE: if (addr_ok) flags[AW'(timer_id)] <= FLAG_FREE;
              OP_TAG: ;
              OP_TIME: if (addr_ok) begin
                flags[AW'(timer_id)] <= FLAG_RUN;
                x_slot <= AW'(timer_id);
                x_dl <= tick_count + delay_ticks;
                cur <= head;
                state <= S_INS_CMP;
              end
              default: ;
            endcase
          end
        end
        S_ALLOC: begin
          if (flags[scan] == FLAG_FREE) begin
            flags[scan] <= FLAG_ALLOC;
            pend_res <= '{kind: KIND_GRANT, slot_id: 4'(scan), tag_out: '0,
                          queue_id: '0, last: 1'b1};
            pend <= 1'b1;
            state <= S_IDLE;
          end else if (32'(scan) == 32'(ADDR_SLOTS - 1)) begin
            pend_res <= '{kind: KIND_FAIL, slot_id: '0, tag_out: '0,
                          queue_id: '0, last: 1'b1};
            pend <= 1'b1;
            state <= S_IDLE;
          end else begin
            scan <= scan + AW'(1);
          end
        end
        S_INS_CMP: begin
          // head compare: rd_dl is deadline of head
          if (x_dl <= rd_dl) begin
            head <= x_slot;
            earliest <= x_dl;
            state <= S_IDLE;
          end else begin
            nxt <= rd_lk;
            steps <= CW'(NUM_SLOTS);
            state <= S_WALK_CMP;
          end
        end
        S_WALK_CMP: begin
          // rd_dl/rd_lk now belong to nxt; predecessor is cur
          if (x_dl <= rd_dl) begin
            state <= S_INS_LINK;
          end else if (steps != CW'(1)) begin
            cur <= nxt;
            nxt <= rd_lk;
            steps <= steps - CW'(1);
          end else begin
            state <= S_IDLE;
          end
        end
        S_INS_LINK: state <= S_IDLE;
        S_POP_CMP: begin
          if (pop_go) begin
            flags[cur] <= FLAG_ALLOC;
            pend_res <= '{kind: KIND_EXP, slot_id: 4'(cur),
                          tag_out: rd_tq[34:3], queue_id: rd_tq[2:0], last: 1'b0};
            held <= 1'b1;
            cur <= rd_lk;
            pops <= pops - FW'(1);
            state <= S_POP_RD;
          end else if (pop_end) begin
            held <= 1'b0;
            head <= cur;
            earliest <= rd_dl;
            state <= S_DONE;
          end
        end
        S_POP_RD: state <= S_POP_CMP;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/sorted_multi_timer_queue.sv */
// sorted_multi_timer_queue: top level of the sorted timer list
// depends on smtq_pkg, smtq_engine, smtq_out_reg
// set time compares against the head first, then walks the list; free, set tag, unknown and a
//   tick with nothing due walk nothing; alloc scans slots 0 to min(NUM_SLOTS,16)-1 in order
// a tick pops due timers in deadline order, one expiry word each, the last marked; output stalls hold the engine
// sync reset: only the sentinel in the list, count zero; sentinel deadline written during rst
module sorted_multi_timer_queue #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [3:0]        timer_id,
  input  logic [31:0]       delay_ticks,
  input  logic signed [31:0] tag_value,
  input  logic [2:0]        queue_select,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [3:0]        slot_id,
  output logic signed [31:0] tag_out,
  output logic [2:0]        queue_id,
  output logic              last
);
  import smtq_pkg::*;
  logic    ld, busy;
  result_t r, q;
  // engine walks the list in memory, one compare per cycle while inserting
  smtq_engine #(.NUM_SLOTS(NUM_SLOTS)) u_eng (
    .clk, .rst, .in_valid, .in_stall, .opcode, .timer_id, .delay_ticks,
    .tag_value, .queue_select, .res_load(ld), .res(r), .res_busy(busy));
  // one result word register toward the receiver
  smtq_out_reg u_out (
    .clk, .rst, .load(ld), .din(r), .busy, .out_valid, .out_stall, .dout(q));
  assign kind = q.kind;
  assign slot_id = q.slot_id;
  assign tag_out = q.tag_out;
  assign queue_id = q.queue_id;
  assign last = q.last;
endmodule

/* tb/smtq_checker.sv */
// smtq_checker: watches both channels of the sorted timer queue, predicts results
// depends on smtq_pkg
`timescale 1ns / 100ps
module smtq_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic [3:0]         timer_id,
  input  logic [31:0]        delay_ticks,
  input  logic signed [31:0] tag_value,
  input  logic [2:0]         queue_select,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         kind,
  input  logic [3:0]         slot_id,
  input  logic signed [31:0] tag_out,
  input  logic [2:0]         queue_id,
  input  logic               last,
  output int                 fail_count,
  output int                 pending_count,
  output logic               accepted_any
);
  import smtq_pkg::*;

  localparam int ADDR = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [2:0]  queue;
    logic        last;
  } notice_t;

  flag_t       flags [NUM_SLOTS];
  logic [31:0] deadline [NUM_SLOTS];
  logic [31:0] tags [NUM_SLOTS];
  logic [2:0]  queues [NUM_SLOTS];
  int          link [NUM_SLOTS];
  int          head;
  logic [31:0] now;
  logic [31:0] earliest;
  notice_t     expected_notices [$];

  assign pending_count = expected_notices.size();

  task automatic link_timer(input int x);
    int s;
    int t;
    s = head;
    if (deadline[x] <= deadline[s]) begin
      link[x] = s;
      head = x;
      earliest = deadline[x];
      return;
    end
    for (int n = 0; n < NUM_SLOTS; n++) begin
      t = link[s];
      if (deadline[x] <= deadline[t]) begin
        link[s] = x;
        link[x] = t;
        return;
      end
      s = t;
    end
  endtask

  // apply one accepted word to the model state, queue its notices
  task automatic predict_timers(input logic [2:0] op, input logic [3:0] id,
                                input logic [31:0] dly, input logic [31:0] tg,
                                input logic [2:0] q);
    notice_t batch [$];
    notice_t n;
    int t;
    bit ok;
    bit granted;
    ok = (id != 0) && (id < ADDR);
    case (op)
      OP_TICK: begin
        now = now + 1;
        if (earliest <= now) begin
          t = head;
          while (t != 0 && batch.size() < ADDR && deadline[t] <= now) begin
            flags[t] = FLAG_ALLOC;
            n = '{KIND_EXP, t[3:0], tags[t], queues[t], 1'b0};
            batch.push_back(n);
            t = link[t];
          end
          head = t;
          earliest = deadline[t];
        end
      end
      OP_ALLOC: begin
        granted = 0;
        for (int i = 0; i < ADDR; i++) begin
          if (!granted && flags[i] == FLAG_FREE) begin
            flags[i] = FLAG_ALLOC;
            n = '{KIND_GRANT, i[3:0], 32'd0, 3'd0, 1'b0};
            batch.push_back(n);
            granted = 1;
          end
        end
        if (!granted) begin
          n = '{KIND_FAIL, 4'd0, 32'd0, 3'd0, 1'b0};
          batch.push_back(n);
        end
      end
      OP_FREE: if (ok) flags[id] = FLAG_FREE;
      OP_TAG: if (ok) begin
        tags[id] = tg;
        queues[id] = q;
      end
      OP_TIME: if (ok) begin
        deadline[id] = now + dly;
        flags[id] = FLAG_RUN;
        link_timer(id);
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_notices.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    notice_t e;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        flags[i] = FLAG_FREE;
        deadline[i] = '0;
        tags[i] = '0;
        queues[i] = '0;
        link[i] = 0;
      end
      flags[0] = FLAG_RUN;
      deadline[0] = ALL_ONES;
      head = 0;
      now = '0;
      earliest = ALL_ONES;
      expected_notices.delete();
      fail_count = 0;
      accepted_any = 1'b0;
    end else begin
      accepted_any = 1'b0;
      // result side first: a word can't produce a result in its own cycle
      if (out_valid && !out_stall) begin
        accepted_any = 1'b1;
        if (expected_notices.size() == 0) begin
          $error("unexpected result word kind=%0d slot=%0d", kind, slot_id);
          fail_count++;
        end else begin
          e = expected_notices.pop_front();
          if (kind !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, kind); fail_count++;
          end
          if (slot_id !== e.slot) begin
            $error("slot_id: expected %0d actual %0d", e.slot, slot_id); fail_count++;
          end
          if (tag_out !== e.tag) begin
            $error("tag_out: expected %h actual %h", e.tag, tag_out); fail_count++;
          end
          if (queue_id !== e.queue) begin
            $error("queue_id: expected %0d actual %0d", e.queue, queue_id); fail_count++;
          end
          if (last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, last); fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        accepted_any = 1'b1;
        predict_timers(opcode, timer_id, delay_ticks, tag_value, queue_select);
      end
    end
  end
endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for the sorted timer queue
// depends on smtq_pkg, sorted_multi_timer_queue and smtq_checker
`timescale 1ns / 100ps
module tb;
  import smtq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] opcode, queue_select, queue_id;
  logic [3:0] timer_id, slot_id;
  logic [31:0] delay_ticks;
  logic signed [31:0] tag_value, tag_out;
  logic [1:0] kind;
  logic last;
  int fail_count, pending_count;
  logic accepted_any;

  // idle / stall percentages per phase, and long hold-off request
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  bit tagged_slot [16];    // slots that have had a tag written

  sorted_multi_timer_queue DUT (.*);
  smtq_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: cycles in a row with nothing accepted on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      quiet = accepted_any ? 0 : quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // offer one word and hold it until taken
  task automatic send_word(input logic [2:0] op, input logic [3:0] id,
                           input logic [31:0] dly, input logic [31:0] tg,
                           input logic [2:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    timer_id <= id;
    delay_ticks <= dly;
    tag_value <= tg;
    queue_select <= q;
    if (op == OP_TAG && id != 4'd0) tagged_slot[id] = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // a timer may only run once its slot has a tag, so untagged storage is never read
  task automatic arm_timer(input logic [3:0] id, input logic [31:0] dly);
    if (!tagged_slot[id])
      send_word(OP_TAG, id, 32'd0, $urandom, 3'($urandom_range(7)));
    send_word(OP_TIME, id, dly, 32'd0, 3'd0);
  endtask

  task automatic random_word();
    int r;
    logic [3:0] id;
    r = $urandom_range(99);
    id = 4'($urandom_range(15));
    if (r < 35) send_word(OP_TICK, 4'($urandom), $urandom, $urandom, 3'($urandom));
    else if (r < 50) send_word(OP_ALLOC, 4'($urandom), $urandom, $urandom, 3'($urandom));
    else if (r < 58) send_word(OP_FREE, id, $urandom, $urandom, 3'($urandom));
    else if (r < 70) send_word(OP_TAG, id, $urandom, $urandom, 3'($urandom_range(7)));
    else if (r < 94) begin
      // mostly short delays so timers fire, some huge ones
      if (id == 4'd0 || tagged_slot[id])
        send_word(OP_TIME, id, ($urandom_range(9) == 0) ? $urandom : $urandom_range(12),
                  $urandom, 3'($urandom));
      else arm_timer(id, $urandom_range(12));
    end else send_word(3'($urandom_range(7, 5)), id, $urandom, $urandom, 3'($urandom));
  endtask

  initial begin
    in_valid = 1'b0; opcode = '0; timer_id = '0; delay_ticks = '0;
    tag_value = '0; queue_select = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: fill the pool, overflow alloc, extremes, sentinel, bad opcode
    repeat (16) send_word(OP_ALLOC, 4'd0, 32'd0, 32'd0, 3'd0);
    send_word(OP_TAG, 4'd1, 32'd0, 32'h7fff_ffff, 3'd7);
    send_word(OP_TAG, 4'd2, 32'd0, 32'h8000_0000, 3'd0);
    send_word(OP_TAG, 4'd0, 32'd0, 32'hffff_ffff, 3'd5);   // sentinel, ignored
    send_word(OP_TIME, 4'd0, 32'd1, 32'd0, 3'd0);          // sentinel, ignored
    arm_timer(4'd1, 32'd2);
    arm_timer(4'd2, 32'd2);                                // equal deadline goes ahead
    arm_timer(4'd3, 32'hffff_ffff);
    send_word(OP_FREE, 4'd2, 32'd0, 32'd0, 3'd0);          // freed but still linked
    send_word(3'd7, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 3'd7);
    repeat (3) send_word(OP_TICK, 4'd0, 32'd0, 32'd0, 3'd0);
    send_word(OP_ALLOC, 4'd0, 32'd0, 32'd0, 3'd0);

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 35 : 57) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 35 : 57) : 0;
      if (ph == 0) hold_off = 1'b1;
      repeat (110) random_word();
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
